FILE: src/first_fit_segment_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// First-fit segment allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FFSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsa check failed");

// next-cycle implication
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsa check failed");

`endif

FILE: src/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int POOL_ITEMS   = 4096;
    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int START_W      = 12;
    localparam int LEN_W        = 13;
    localparam int NEED_W       = LEN_W + 1;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_GROW  = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_SPACE   = 2'd1,
        STATUS_TABLE_FULL = 2'd2,
        STATUS_NO_ALLOC   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_GROW,
        OP_FREE,
        OP_RELOC,
        OP_RFREE
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_RDP,
        ST_RDN,
        ST_NB,
        ST_COPY,
        ST_WR0,
        ST_WR1,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               used;
        logic [LEN_W-1:0]   len;
        logic [START_W-1:0] start;
    } seg_t;

    localparam int SEG_W = $bits(seg_t);

endpackage

FILE: src/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit allocator over a pool of item slots with in-place grow and
// coalescing free, kept as an address-ordered segment table in one RAM.
// ----------------------------------------------------------------------------
// One request at a time. A request scans the segment table one entry per
// cycle (one RAM read port, registered read) until it finds its segment,
// then shifts the table tail one entry per cycle when a segment is split or
// removed, and ends with up to two entry writes. A relocating grow runs a lookup,
// a first-fit pass with its shift and a free with its shift in a row. After
// reset the state ST_INIT writes the initial free segment before the first
// request is taken.
module first_fit_segment_allocator_top
    import ffsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // item_count[12:0], alloc_offset[24:13]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_offset[11:0], result_length[24:12], moved[25]
    output logic [1:0]  m_tuser    // status[1:0]
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [START_W-1:0] off_reg, off_next;
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]  cur_idx_reg, cur_idx_next;
    logic [START_W-1:0] cur_s_reg, cur_s_next;
    logic [LEN_W-1:0]   cur_l_reg, cur_l_next;
    seg_t               prev_reg, prev_next;
    logic [ADDR_W-1:0]  cp_src_reg, cp_src_next;
    logic [CNT_W-1:0]   cp_left_reg, cp_left_next;
    logic               cp_up_reg, cp_up_next;
    logic [1:0]         cp_gap_reg, cp_gap_next;
    seg_t               wr0_reg, wr0_next, wr1_reg, wr1_next;
    logic [ADDR_W-1:0]  wr0_idx_reg, wr0_idx_next, wr1_idx_reg, wr1_idx_next;
    logic               wr1_en_reg, wr1_en_next;
    status_t            res_st_reg, res_st_next;
    logic [START_W-1:0] res_off_reg, res_off_next;
    logic [LEN_W-1:0]   res_len_reg, res_len_next;
    logic               res_mv_reg, res_mv_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_st_reg, out_st_next;
    logic [START_W-1:0] out_off_reg, out_off_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_mv_reg, out_mv_next;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    seg_t              ram_wdata;
    logic [SEG_W-1:0]  ram_rdata;
    seg_t              rd_seg;

    logic               fit_scan, scan_more, find_hit, fit_hit, scan_hit, scan_miss;
    logic               fit_exact, table_full;
    logic               prev_free, next_ok, next_free, grow_fits, grow_eats;
    logic [CNT_W-1:0]   cur_wide, hi_idx;
    logic [ADDR_W-1:0]  lo_idx;
    logic [START_W-1:0] merge_s;
    logic [LEN_W-1:0]   merge_l;
    logic               s_accept, out_load;

    ffsa_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_ffsa_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_seg     = seg_t'(ram_rdata);
    assign fit_scan   = (op_reg == OP_ALLOC) || (op_reg == OP_RELOC);
    assign scan_more  = scan_idx_reg < total_reg;
    assign find_hit   = pend_reg && rd_seg.used && (rd_seg.start == off_reg);
    assign fit_hit    = pend_reg && !rd_seg.used && ({1'b0, rd_seg.len} >= need_reg);
    assign scan_hit   = fit_scan ? fit_hit : find_hit;
    assign scan_miss  = !pend_reg && !scan_more;
    assign fit_exact  = {1'b0, rd_seg.len} == need_reg;
    assign table_full = total_reg == CNT_W'(MAX_SEGMENTS);

    assign cur_wide  = {1'b0, cur_idx_reg};
    assign prev_free = (cur_idx_reg != '0) && !prev_reg.used;
    assign next_ok   = (cur_wide + CNT_W'(1)) < total_reg;
    assign next_free = next_ok && !rd_seg.used;
    assign grow_fits = next_free && (rd_seg.len >= cnt_reg);
    assign grow_eats = rd_seg.len == cnt_reg;
    assign lo_idx    = prev_free ? (cur_idx_reg - ADDR_W'(1)) : cur_idx_reg;
    assign hi_idx    = next_free ? (cur_wide + CNT_W'(1)) : cur_wide;
    assign merge_s   = prev_free ? prev_reg.start : cur_s_reg;
    assign merge_l   = (prev_free ? prev_reg.len : '0) + cur_l_reg
                     + (next_free ? rd_seg.len : '0);

    assign s_accept = (state_reg == ST_IDLE) && s_tvalid;
    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_tuser)
                        MODE_ALLOC:
                        begin
                            state_next = (s_tdata[12:0] == '0) ? ST_RESP : ST_SCAN;
                        end
                        MODE_GROW, MODE_FREE:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    if (fit_scan)
                    begin
                        if (fit_exact)
                        begin
                            state_next = ST_WR0;
                        end
                        else if (table_full)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_COPY;
                        end
                    end
                    else if ((op_reg == OP_GROW) && (cnt_reg == '0))
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_RDP;
                    end
                end
                else if (scan_miss)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RDP:
            begin
                state_next = ST_RDN;
            end
            ST_RDN:
            begin
                state_next = ST_NB;
            end
            ST_NB:
            begin
                if ((op_reg == OP_GROW) && !grow_fits)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if ((cp_left_reg == '0) && !pend_reg)
                begin
                    state_next = ST_WR0;
                end
            end
            ST_WR0:
            begin
                if (wr1_en_reg)
                begin
                    state_next = ST_WR1;
                end
                else
                begin
                    state_next = (op_reg == OP_RELOC) ? ST_RDP : ST_RESP;
                end
            end
            ST_WR1:
            begin
                state_next = (op_reg == OP_RELOC) ? ST_RDP : ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        off_next      = off_reg;
        need_next     = need_reg;
        total_next    = total_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        cur_idx_next  = cur_idx_reg;
        cur_s_next    = cur_s_reg;
        cur_l_next    = cur_l_reg;
        prev_next     = prev_reg;
        cp_src_next   = cp_src_reg;
        cp_left_next  = cp_left_reg;
        cp_up_next    = cp_up_reg;
        cp_gap_next   = cp_gap_reg;
        wr0_next      = wr0_reg;
        wr1_next      = wr1_reg;
        wr0_idx_next  = wr0_idx_reg;
        wr1_idx_next  = wr1_idx_reg;
        wr1_en_next   = wr1_en_reg;
        res_st_next   = res_st_reg;
        res_off_next  = res_off_reg;
        res_len_next  = res_len_reg;
        res_mv_next   = res_mv_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{used: 1'b0, len: LEN_W'(POOL_ITEMS), start: '0};
                total_next = CNT_W'(1);
            end
            ST_IDLE:
            begin
                cnt_next      = s_tdata[12:0];
                off_next      = s_tdata[24:13];
                need_next     = {1'b0, s_tdata[12:0]};
                scan_idx_next = '0;
                res_st_next   = STATUS_OK;
                res_off_next  = '0;
                res_len_next  = '0;
                res_mv_next   = 1'b0;
                case (s_tuser)
                    MODE_ALLOC:
                    begin
                        op_next = OP_ALLOC;
                        if (s_tdata[12:0] == '0)
                        begin
                            res_st_next = STATUS_NO_SPACE;
                        end
                    end
                    MODE_GROW:
                    begin
                        op_next = OP_GROW;
                    end
                    default:
                    begin
                        op_next = OP_FREE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_more)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[ADDR_W-1:0];
                end
                if (scan_hit)
                begin
                    pend_next = 1'b0;
                    if (fit_scan)
                    begin
                        if (fit_exact)
                        begin
                            wr0_idx_next = pend_idx_reg;
                            wr0_next     = '{used: 1'b1, len: rd_seg.len, start: rd_seg.start};
                            wr1_en_next  = 1'b0;
                            res_off_next = rd_seg.start;
                            res_len_next = rd_seg.len;
                            res_mv_next  = op_reg == OP_RELOC;
                        end
                        else if (table_full)
                        begin
                            res_st_next = STATUS_TABLE_FULL;
                        end
                        else
                        begin
                            cp_src_next  = ADDR_W'(total_reg - CNT_W'(1));
                            cp_left_next = total_reg - CNT_W'(1) - {1'b0, pend_idx_reg};
                            cp_up_next   = 1'b1;
                            cp_gap_next  = 2'd1;
                            wr0_idx_next = pend_idx_reg;
                            wr0_next     = '{used: 1'b1, len: need_reg[LEN_W-1:0],
                                             start: rd_seg.start};
                            wr1_idx_next = pend_idx_reg + ADDR_W'(1);
                            wr1_next     = '{used: 1'b0,
                                             len: rd_seg.len - need_reg[LEN_W-1:0],
                                             start: rd_seg.start + need_reg[START_W-1:0]};
                            wr1_en_next  = 1'b1;
                            total_next   = total_reg + CNT_W'(1);
                            res_off_next = rd_seg.start;
                            res_len_next = need_reg[LEN_W-1:0];
                            res_mv_next  = op_reg == OP_RELOC;
                            if ((op_reg == OP_RELOC) && (pend_idx_reg < cur_idx_reg))
                            begin
                                cur_idx_next = cur_idx_reg + ADDR_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        cur_idx_next = pend_idx_reg;
                        cur_s_next   = rd_seg.start;
                        cur_l_next   = rd_seg.len;
                        if ((op_reg == OP_GROW) && (cnt_reg == '0))
                        begin
                            res_off_next = rd_seg.start;
                            res_len_next = rd_seg.len;
                        end
                    end
                end
                else if (scan_miss)
                begin
                    res_st_next = fit_scan ? STATUS_NO_SPACE : STATUS_NO_ALLOC;
                end
            end
            ST_RDP:
            begin
                ram_re    = 1'b1;
                ram_raddr = cur_idx_reg - ADDR_W'(1);
            end
            ST_RDN:
            begin
                prev_next = rd_seg;
                ram_re    = 1'b1;
                ram_raddr = cur_idx_reg + ADDR_W'(1);
            end
            ST_NB:
            begin
                if (op_reg == OP_GROW)
                begin
                    if (grow_fits)
                    begin
                        wr0_idx_next = cur_idx_reg;
                        wr0_next     = '{used: 1'b1, len: cur_l_reg + cnt_reg,
                                         start: cur_s_reg};
                        res_off_next = cur_s_reg;
                        res_len_next = cur_l_reg + cnt_reg;
                        cp_up_next   = 1'b0;
                        cp_gap_next  = 2'd1;
                        cp_src_next  = cur_idx_reg + ADDR_W'(2);
                        if (grow_eats)
                        begin
                            wr1_en_next  = 1'b0;
                            cp_left_next = total_reg - cur_wide - CNT_W'(2);
                            total_next   = total_reg - CNT_W'(1);
                        end
                        else
                        begin
                            wr1_en_next  = 1'b1;
                            wr1_idx_next = cur_idx_reg + ADDR_W'(1);
                            wr1_next     = '{used: 1'b0, len: rd_seg.len - cnt_reg,
                                             start: rd_seg.start + cnt_reg[START_W-1:0]};
                            cp_left_next = '0;
                        end
                    end
                    else
                    begin
                        op_next       = OP_RELOC;
                        need_next     = NEED_W'(cur_l_reg) + NEED_W'(cnt_reg);
                        scan_idx_next = '0;
                    end
                end
                else
                begin
                    wr0_idx_next = lo_idx;
                    wr0_next     = '{used: 1'b0, len: merge_l, start: merge_s};
                    wr1_en_next  = 1'b0;
                    cp_up_next   = 1'b0;
                    cp_gap_next  = {1'b0, prev_free} + {1'b0, next_free};
                    cp_src_next  = ADDR_W'(hi_idx + CNT_W'(1));
                    cp_left_next = total_reg - CNT_W'(1) - hi_idx;
                    total_next   = total_reg - CNT_W'(prev_free) - CNT_W'(next_free);
                    if (op_reg == OP_FREE)
                    begin
                        res_off_next = off_reg;
                    end
                end
            end
            ST_COPY:
            begin
                if (cp_left_reg != '0)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = cp_src_reg;
                    pend_next     = 1'b1;
                    pend_idx_next = cp_src_reg;
                    cp_src_next   = cp_up_reg ? (cp_src_reg - ADDR_W'(1))
                                              : (cp_src_reg + ADDR_W'(1));
                    cp_left_next  = cp_left_reg - CNT_W'(1);
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_up_reg ? (pend_idx_reg + ADDR_W'(1))
                                          : (pend_idx_reg - ADDR_W'(cp_gap_reg));
                    ram_wdata = rd_seg;
                end
            end
            ST_WR0:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr0_idx_reg;
                ram_wdata = wr0_reg;
                if (!wr1_en_reg && (op_reg == OP_RELOC))
                begin
                    op_next = OP_RFREE;
                end
            end
            ST_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr1_idx_reg;
                ram_wdata = wr1_reg;
                if (op_reg == OP_RELOC)
                begin
                    op_next = OP_RFREE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_st_next    = out_st_reg;
        out_off_next   = out_off_reg;
        out_len_next   = out_len_reg;
        out_mv_next    = out_mv_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_st_next    = res_st_reg;
            out_off_next   = res_off_reg;
            out_len_next   = res_len_reg;
            out_mv_next    = res_mv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            op_reg        <= OP_ALLOC;
            total_reg     <= CNT_W'(1);
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            cp_left_reg   <= '0;
            wr1_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            total_reg     <= total_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            cp_left_reg   <= cp_left_next;
            wr1_en_reg    <= wr1_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        off_reg      <= off_next;
        need_reg     <= need_next;
        pend_idx_reg <= pend_idx_next;
        cur_idx_reg  <= cur_idx_next;
        cur_s_reg    <= cur_s_next;
        cur_l_reg    <= cur_l_next;
        prev_reg     <= prev_next;
        cp_src_reg   <= cp_src_next;
        cp_up_reg    <= cp_up_next;
        cp_gap_reg   <= cp_gap_next;
        wr0_reg      <= wr0_next;
        wr1_reg      <= wr1_next;
        wr0_idx_reg  <= wr0_idx_next;
        wr1_idx_reg  <= wr1_idx_next;
        res_st_reg   <= res_st_next;
        res_off_reg  <= res_off_next;
        res_len_reg  <= res_len_next;
        res_mv_reg   <= res_mv_next;
        out_st_reg   <= out_st_next;
        out_off_reg  <= out_off_next;
        out_len_reg  <= out_len_next;
        out_mv_reg   <= out_mv_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_mv_reg, out_len_reg, out_off_reg};
    assign m_tuser  = out_st_reg;

endmodule

FILE: src/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the first-fit segment allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_top_defines.svh"

module ffsa_checker
    import ffsa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `FFSA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `FFSA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `FFSA_ASSERT_NOW(a_fail_zero, clk, rst_n, m_tvalid && (m_tuser != STATUS_OK), m_tdata[25:0] == 26'd0)
    `FFSA_ASSERT_NOW(a_moved_ok, clk, rst_n, m_tvalid && m_tdata[25], (m_tuser == STATUS_OK) && (m_tdata[24:12] != 13'd0))

endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (.*);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the first-fit segment allocator. Drives allocate, grow, free and
// mode-3 requests with random gaps on both sides, predicts every response from
// a software copy of the segment table, and compares the responses in order.
// ----------------------------------------------------------------------------
module tb_top
    import ffsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] offset;
        logic [LEN_W-1:0]   length;
        logic               moved;
    } reply_t;

    typedef struct {
        logic [1:0]         mode;
        logic [12:0]        count;
        logic [11:0]        offset;
        logic               fixed;
        reply_t             reply;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int     seg_start [MAX_SEGMENTS];
    int     seg_len [MAX_SEGMENTS];
    bit     seg_used [MAX_SEGMENTS];
    int     seg_total;
    reply_t pending_replies [$];
    int     errors;
    longint cycles;
    bit     stim_done;

    first_fit_segment_allocator_top dut (.*);

    always #5 clk = ~clk;

    function automatic void table_reset();
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            seg_start[i] = 0;
            seg_len[i] = 0;
            seg_used[i] = 0;
        end
        seg_len[0] = POOL_ITEMS;
        seg_total = 1;
    endfunction

    function automatic void table_remove(int i);
        for (int j = i; j + 1 < seg_total; j++)
        begin
            seg_start[j] = seg_start[j + 1];
            seg_len[j] = seg_len[j + 1];
            seg_used[j] = seg_used[j + 1];
        end
        seg_total--;
        seg_start[seg_total] = 0;
        seg_len[seg_total] = 0;
        seg_used[seg_total] = 0;
    endfunction

    function automatic int find_alloc(int off);
        for (int i = 0; i < seg_total; i++)
            if (seg_used[i] && seg_start[i] == off)
                return i;
        return -1;
    endfunction

    function automatic int place_first_fit(int n, ref status_t st);
        for (int i = 0; i < seg_total; i++)
        begin
            if (seg_used[i] || seg_len[i] < n)
                continue;
            if (seg_len[i] == n)
            begin
                seg_used[i] = 1;
                return i;
            end
            if (seg_total >= MAX_SEGMENTS)
            begin
                st = STATUS_TABLE_FULL;
                return -1;
            end
            for (int j = seg_total; j > i; j--)
            begin
                seg_start[j] = seg_start[j - 1];
                seg_len[j] = seg_len[j - 1];
                seg_used[j] = seg_used[j - 1];
            end
            seg_total++;
            seg_used[i] = 1;
            seg_len[i] = n;
            seg_start[i + 1] += n;
            seg_len[i + 1] -= n;
            return i;
        end
        st = STATUS_NO_SPACE;
        return -1;
    endfunction

    function automatic void release_segment(int i);
        seg_used[i] = 0;
        if (i > 0 && !seg_used[i - 1])
        begin
            seg_len[i - 1] += seg_len[i];
            table_remove(i);
            i--;
        end
        if (i + 1 < seg_total && !seg_used[i + 1])
        begin
            seg_start[i + 1] = seg_start[i];
            seg_len[i + 1] += seg_len[i];
            table_remove(i);
        end
    endfunction

    function automatic reply_t predict_reply(logic [1:0] mode, int n, int off);
        reply_t r;
        status_t st;
        int i;
        int k;
        st = STATUS_OK;
        r = '{STATUS_OK, '0, '0, 1'b0};
        if (mode == MODE_ALLOC)
        begin
            if (n == 0)
                st = STATUS_NO_SPACE;
            else
            begin
                k = place_first_fit(n, st);
                if (k >= 0)
                begin
                    r.offset = START_W'(seg_start[k]);
                    r.length = LEN_W'(seg_len[k]);
                end
            end
        end
        else if (mode == MODE_GROW)
        begin
            i = find_alloc(off);
            if (i < 0)
                st = STATUS_NO_ALLOC;
            else if (n == 0)
            begin
                r.offset = START_W'(seg_start[i]);
                r.length = LEN_W'(seg_len[i]);
            end
            else if (i + 1 < seg_total && !seg_used[i + 1] && seg_len[i + 1] >= n)
            begin
                seg_len[i] += n;
                seg_start[i + 1] += n;
                seg_len[i + 1] -= n;
                if (seg_len[i + 1] == 0)
                    table_remove(i + 1);
                r.offset = START_W'(seg_start[i]);
                r.length = LEN_W'(seg_len[i]);
            end
            else
            begin
                k = place_first_fit(seg_len[i] + n, st);
                if (k >= 0)
                begin
                    r.offset = START_W'(seg_start[k]);
                    r.length = LEN_W'(seg_len[k]);
                    r.moved = 1'b1;
                    i = find_alloc(off);
                    if (i >= 0)
                        release_segment(i);
                end
            end
        end
        else if (mode == MODE_FREE)
        begin
            i = find_alloc(off);
            if (i < 0)
                st = STATUS_NO_ALLOC;
            else
            begin
                release_segment(i);
                r.offset = START_W'(off);
            end
        end
        r.status = st;
        return r;
    endfunction

    function automatic int gap_cycles();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int pick_offset();
        int i;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 4095);
        i = $urandom_range(0, seg_total - 1);
        return seg_start[i];
    endfunction

    task automatic send_request(logic [1:0] mode, logic [12:0] n, logic [11:0] off,
                                bit fixed, reply_t want);
        reply_t r;
        int     g;
        r = predict_reply(mode, n, off);
        if (fixed && r != want)
        begin
            $display("%0t table row mismatch: expected %p actual %p", $time, want, r);
            errors++;
        end
        pending_replies = {pending_replies, r};
        g = gap_cycles();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {7'd0, off, n};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected transaction: actual %h/%h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_tuser != want.status || m_tdata[11:0] != want.offset ||
                    m_tdata[24:12] != want.length || m_tdata[25] != want.moved ||
                    m_tdata[31:26] != 0)
                begin
                    $display("%0t mismatch: expected st=%0d off=%0d len=%0d mv=%0d",
                             $time, want.status, want.offset, want.length, want.moved);
                    $display("%0t           actual   st=%0d off=%0d len=%0d mv=%0d",
                             $time, m_tuser, m_tdata[11:0], m_tdata[24:12], m_tdata[25]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stim_done && pending_replies.size() == 0)
            m_tready <= 1'b1;
        else
        begin
            g = $urandom_range(0, 19);
            m_tready <= (g < 13) ? 1'b1 : (g == 19 ? 1'b0 : ($urandom_range(0, 1) == 1));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 5000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        row_t   rows [21];
        int     k;
        int     m;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = MODE_ALLOC;
        errors = 0;
        cycles = 0;
        stim_done = 0;
        table_reset();
        rows = '{
            '{MODE_ALLOC, 13'd0,    12'd0,    1, '{STATUS_NO_SPACE, 0, 0, 0}},
            '{MODE_FREE,  13'd1,    12'd0,    1, '{STATUS_NO_ALLOC, 0, 0, 0}},
            '{MODE_GROW,  13'd1,    12'd4095, 1, '{STATUS_NO_ALLOC, 0, 0, 0}},
            '{MODE_ALLOC, 13'd8191, 12'd0,    1, '{STATUS_NO_SPACE, 0, 0, 0}},
            '{MODE_ALLOC, 13'd4097, 12'd0,    1, '{STATUS_NO_SPACE, 0, 0, 0}},
            '{2'd3,       13'd5,    12'd7,    1, '{STATUS_OK, 0, 0, 0}},
            '{MODE_ALLOC, 13'd4096, 12'd0,    1, '{STATUS_OK, 0, 4096, 0}},
            '{MODE_ALLOC, 13'd1,    12'd0,    1, '{STATUS_NO_SPACE, 0, 0, 0}},
            '{MODE_GROW,  13'd0,    12'd0,    1, '{STATUS_OK, 0, 4096, 0}},
            '{MODE_FREE,  13'd0,    12'd0,    1, '{STATUS_OK, 0, 0, 0}},
            '{MODE_ALLOC, 13'd1,    12'd0,    1, '{STATUS_OK, 0, 1, 0}},
            '{MODE_ALLOC, 13'd10,   12'd0,    1, '{STATUS_OK, 1, 10, 0}},
            '{MODE_GROW,  13'd5,    12'd1,    1, '{STATUS_OK, 1, 15, 0}},
            '{MODE_GROW,  13'd2,    12'd0,    0, '{STATUS_OK, 0, 0, 0}},
            '{MODE_FREE,  13'd0,    12'd1,    0, '{STATUS_OK, 0, 0, 0}},
            '{MODE_GROW,  13'd4093, 12'd16,   0, '{STATUS_OK, 0, 0, 0}},
            '{MODE_GROW,  13'd4000, 12'd0,    0, '{STATUS_OK, 0, 0, 0}},
            '{MODE_FREE,  13'd0,    12'd3,    0, '{STATUS_OK, 0, 0, 0}},
            '{MODE_FREE,  13'd0,    12'd0,    0, '{STATUS_OK, 0, 0, 0}},
            '{MODE_FREE,  13'd0,    12'd16,   0, '{STATUS_OK, 0, 0, 0}},
            '{2'd3,       13'd8191, 12'd4095, 1, '{STATUS_OK, 0, 0, 0}}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1;
        foreach (rows[i])
            send_request(rows[i].mode, rows[i].count, rows[i].offset,
                         rows[i].fixed, rows[i].reply);
        // fill the table with single-item runs to reach the full-table case
        for (int i = 0; i < 70; i++)
            send_request(MODE_ALLOC, 13'd1, 12'd0, 0, '{STATUS_OK, 0, 0, 0});
        for (int i = 0; i < 70; i += 2)
            send_request(MODE_FREE, 13'd0, 12'(i), 0, '{STATUS_OK, 0, 0, 0});
        for (int i = 0; i < 1450; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)
            begin
                m = $urandom_range(0, 9);
                send_request(MODE_ALLOC,
                             13'(m < 7 ? $urandom_range(1, 64) :
                                 (m < 9 ? $urandom_range(0, 600) : $urandom_range(0, 8191))),
                             12'($urandom_range(0, 4095)), 0, '{STATUS_OK, 0, 0, 0});
            end
            else if (k < 65)
                send_request(MODE_GROW,
                             13'($urandom_range(0, 9) < 8 ? $urandom_range(0, 80)
                                                          : $urandom_range(0, 8191)),
                             12'(pick_offset()), 0, '{STATUS_OK, 0, 0, 0});
            else if (k < 97)
                send_request(MODE_FREE, 13'($urandom_range(0, 8191)), 12'(pick_offset()), 0,
                             '{STATUS_OK, 0, 0, 0});
            else
                send_request(2'd3, 13'($urandom_range(0, 8191)),
                             12'($urandom_range(0, 4095)), 0, '{STATUS_OK, 0, 0, 0});
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
